### sv/cnc_pkg.sv
// Package for the cluster normal cone block: types shared by the front end
// and the back end. No dependencies.
`timescale 1ns / 1ps

package cnc_pkg;

  // Classification that the front end attaches to each queued triangle.
  typedef struct packed {
    logic last;  // final triangle of the cluster
    logic drop;  // cluster already full, triangle is discarded
  } tri_flags_t;

  localparam int FLAG_BITS = $bits(tri_flags_t);

endpackage

### sv/cnc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module cnc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 128
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/cnc_fifo.sv
// Short queue between the front end and the back end of the cone block.
// No dependencies.
`timescale 1ns / 1ps

module cnc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wptr_r, rptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign head    = slot_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : PW'(wptr_r + 1'b1);
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : PW'(rptr_r + 1'b1);
      end
      if (do_push && !do_pop) begin
        count_r <= CW'(count_r + 1'b1);
      end else if (do_pop && !do_push) begin
        count_r <= CW'(count_r - 1'b1);
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

endmodule

### sv/cnc_front.sv
// Front end of the cone block: accepts triangles, forms the edges and the
// cross product, and marks items past capacity. Depends on cnc_pkg.
`timescale 1ns / 1ps

module cnc_front #(
  parameter int MAX_TRIANGLES = 128,
  parameter int COORD_BITS    = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] v0_x, v0_y, v0_z,
  input  logic signed [COORD_BITS-1:0] v1_x, v1_y, v1_z,
  input  logic signed [COORD_BITS-1:0] v2_x, v2_y, v2_z,
  input  logic                         last_triangle,
  output logic                         push,
  output logic [3*(2*((COORD_BITS > 30) ? 31 : COORD_BITS + 1) + 1)
                + cnc_pkg::FLAG_BITS - 1:0] push_data,
  input  logic                         q_full
);

  localparam int EW   = (COORD_BITS > 30) ? 31 : COORD_BITS + 1;
  localparam int DROP = (COORD_BITS > 30) ? COORD_BITS - 30 : 0;
  localparam int PW   = 2 * EW;
  localparam int CW   = PW + 1;
  localparam int CNTW = $clog2(MAX_TRIANGLES + 1);

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_CROSS, F_PUSH} fstate_t;

  fstate_t                state_r;
  logic signed [EW-1:0]   e1_r [3];
  logic signed [EW-1:0]   e2_r [3];
  logic signed [PW-1:0]   p_r  [6];
  logic signed [CW-1:0]   c_r  [3];
  cnc_pkg::tri_flags_t    flags_r;
  logic [CNTW-1:0]        fcnt_r;
  logic                   accept, full_now;

  // Edge difference; very wide coordinates lose low magnitude bits.
  function automatic logic signed [EW-1:0] diff_edge(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    logic signed [COORD_BITS:0] d;
    logic [COORD_BITS:0]        m;
    logic [EW-1:0]              mt;
    d  = (COORD_BITS + 1)'(a) - (COORD_BITS + 1)'(b);
    m  = d[COORD_BITS] ? (~d + 1'b1) : d;
    m  = m >> DROP;
    mt = m[EW-1:0];
    diff_edge = d[COORD_BITS] ? $signed(-mt) : $signed(mt);
  endfunction

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != F_IDLE);
  assign full_now = (fcnt_r == CNTW'(MAX_TRIANGLES));
  assign push     = (state_r == F_PUSH) && !q_full;
  assign push_data = {flags_r, c_r[2], c_r[1], c_r[0]};

  // Edges, then products, then the cross product, then a queue push.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      fcnt_r  <= '0;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (accept) begin
            e1_r[0] <= diff_edge(v1_x, v0_x);
            e1_r[1] <= diff_edge(v1_y, v0_y);
            e1_r[2] <= diff_edge(v1_z, v0_z);
            e2_r[0] <= diff_edge(v2_x, v0_x);
            e2_r[1] <= diff_edge(v2_y, v0_y);
            e2_r[2] <= diff_edge(v2_z, v0_z);
            flags_r.last <= last_triangle;
            flags_r.drop <= full_now;
            if (last_triangle) begin
              fcnt_r <= '0;
            end else if (!full_now) begin
              fcnt_r <= CNTW'(fcnt_r + 1'b1);
            end
            state_r <= F_MUL;
          end
        end
        F_MUL: begin
          p_r[0]  <= e1_r[1] * e2_r[2];
          p_r[1]  <= e1_r[2] * e2_r[1];
          p_r[2]  <= e1_r[2] * e2_r[0];
          p_r[3]  <= e1_r[0] * e2_r[2];
          p_r[4]  <= e1_r[0] * e2_r[1];
          p_r[5]  <= e1_r[1] * e2_r[0];
          state_r <= F_CROSS;
        end
        F_CROSS: begin
          c_r[0]  <= CW'(p_r[0]) - CW'(p_r[1]);
          c_r[1]  <= CW'(p_r[2]) - CW'(p_r[3]);
          c_r[2]  <= CW'(p_r[4]) - CW'(p_r[5]);
          state_r <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

### sv/cnc_norm.sv
// Vector normaliser of the cone block: scales a nonzero vector to a unit
// vector in signed Q1.(NORMAL_BITS-1), with a bitwise root and three serial
// dividers; a zero vector gives zero. No dependencies.
`timescale 1ns / 1ps

module cnc_norm #(
  parameter int NW          = 52,
  parameter int NORMAL_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [NW-1:0]          vx, vy, vz,
  output logic                          done,
  output logic signed [NORMAL_BITS-1:0] nx, ny, nz
);

  localparam int RW  = (NW > 30) ? NW : 30;
  localparam int NB  = NORMAL_BITS;
  localparam int QW  = NB + 1;
  localparam int DW  = NB + 30;
  localparam int QCW = $clog2(QW);
  localparam logic [QW-1:0] QMAX = QW'({(NB - 1){1'b1}});

  typedef enum logic [2:0] {
    N_IDLE, N_SHIFT, N_SQ, N_SUM, N_ROOT, N_DIVI, N_DIV, N_OUT
  } nstate_t;

  nstate_t               state_r;
  logic [RW-1:0]         mg_r  [3];
  logic                  neg_r [3];
  logic [59:0]           sq_r  [3];
  logic [61:0]           x_r, bit_r;
  logic [62:0]           r_r, rt;
  logic [30:0]           len_r;
  logic [QW-1:0]         nlo_r [3];
  logic [31:0]           rem_r [3];
  logic [QW-1:0]         q_r   [3];
  logic [QCW-1:0]        cnt_r;
  logic signed [NB-1:0]  res_r [3];
  logic                  done_r;
  logic [NW-1:0]         mag_in [3];
  logic signed [NW-1:0]  vin    [3];
  logic [RW-1:0]         m01, mmax;
  logic [DW-1:0]         num    [3];
  logic [31:0]           rs     [3];
  logic                  ge     [3];
  logic [QW-1:0]         qn     [3];
  logic [QW-1:0]         qs     [3];

  assign vin[0] = vx;
  assign vin[1] = vy;
  assign vin[2] = vz;
  assign done   = done_r;
  assign nx     = res_r[0];
  assign ny     = res_r[1];
  assign nz     = res_r[2];

  // Per-lane magnitudes, dividend, division step and saturation.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_in[i] = vin[i][NW-1] ? (~vin[i] + 1'b1) : vin[i];
      num[i]    = {mg_r[i][29:0], {(NB - 1){1'b0}}} + DW'(len_r >> 1);
      rs[i]     = {rem_r[i][30:0], nlo_r[i][QW-1]};
      ge[i]     = (rs[i] >= {1'b0, len_r});
      qn[i]     = {q_r[i][QW-2:0], ge[i]};
      qs[i]     = (qn[i] > QMAX) ? QMAX : qn[i];
    end
    m01  = (mg_r[0] > mg_r[1]) ? mg_r[0] : mg_r[1];
    mmax = (m01 > mg_r[2]) ? m01 : mg_r[2];
    rt   = r_r + {1'b0, bit_r};
  end

  // Sequencer: scale, square, root, divide.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      done_r  <= 1'b0;
    end else begin
      case (state_r)
        N_IDLE: begin
          done_r <= start && (vx == '0 && vy == '0 && vz == '0);
          if (start) begin
            for (int i = 0; i < 3; i++) begin
              mg_r[i]  <= RW'(mag_in[i]);
              neg_r[i] <= vin[i][NW-1];
            end
            if (vx == '0 && vy == '0 && vz == '0) begin
              for (int i = 0; i < 3; i++) begin
                res_r[i] <= '0;
              end
            end else begin
              state_r <= N_SHIFT;
            end
          end
        end
        // Bring the largest magnitude into [2^29, 2^30), coarse steps first.
        N_SHIFT: begin
          if ((mmax >> 38) != '0) begin
            for (int i = 0; i < 3; i++) mg_r[i] <= mg_r[i] >> 8;
          end else if ((mmax >> 30) != '0) begin
            for (int i = 0; i < 3; i++) mg_r[i] <= mg_r[i] >> 1;
          end else if ((mmax >> 21) == '0) begin
            for (int i = 0; i < 3; i++) mg_r[i] <= mg_r[i] << 8;
          end else if ((mmax >> 29) == '0) begin
            for (int i = 0; i < 3; i++) mg_r[i] <= mg_r[i] << 1;
          end else begin
            state_r <= N_SQ;
          end
        end
        N_SQ: begin
          for (int i = 0; i < 3; i++) begin
            sq_r[i] <= mg_r[i][29:0] * mg_r[i][29:0];
          end
          state_r <= N_SUM;
        end
        N_SUM: begin
          x_r     <= 62'(sq_r[0]) + 62'(sq_r[1]) + 62'(sq_r[2]);
          r_r     <= '0;
          bit_r   <= 62'(1) << 60;
          state_r <= N_ROOT;
        end
        // One result bit of the integer square root per cycle.
        N_ROOT: begin
          if ({1'b0, x_r} >= rt) begin
            x_r <= x_r - rt[61:0];
            r_r <= (r_r >> 1) + {1'b0, bit_r};
          end else begin
            r_r <= r_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r == 62'(1)) begin
            state_r <= N_DIVI;
          end
        end
        N_DIVI: begin
          len_r   <= r_r[30:0];
          state_r <= N_DIV;
          cnt_r   <= QCW'(QW - 1);
          for (int i = 0; i < 3; i++) begin
            q_r[i] <= '0;
          end
        end
        // Load the rounded dividend of each lane.
        N_DIV: begin
          for (int i = 0; i < 3; i++) begin
            rem_r[i] <= 32'(num[i] >> QW);
            nlo_r[i] <= num[i][QW-1:0];
          end
          state_r <= N_OUT;
        end
        // One quotient bit per lane per cycle; the last step saturates and signs.
        N_OUT: begin
          for (int i = 0; i < 3; i++) begin
            rem_r[i] <= ge[i] ? (rs[i] - {1'b0, len_r}) : rs[i];
            q_r[i]   <= qn[i];
            nlo_r[i] <= nlo_r[i] << 1;
          end
          done_r <= (cnt_r == '0);
          if (cnt_r == '0) begin
            state_r <= N_IDLE;
            for (int i = 0; i < 3; i++) begin
              res_r[i] <= neg_r[i] ? -$signed(NB'(qs[i])) : $signed(NB'(qs[i]));
            end
          end else begin
            cnt_r <= QCW'(cnt_r - 1'b1);
          end
        end
        default: state_r <= N_IDLE;
      endcase
    end
  end

endmodule

### sv/cnc_back.sv
// Back end of the cone block: normalises each queued cross product not marked
// dropped, keeps the normals and their sum, and on the last triangle builds
// the axis and the cutoff. Depends on cnc_pkg, cnc_norm and cnc_ram.
`timescale 1ns / 1ps

module cnc_back #(
  parameter int MAX_TRIANGLES = 128,
  parameter int COORD_BITS    = 24,
  parameter int NORMAL_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  logic [3*(2*((COORD_BITS > 30) ? 31 : COORD_BITS + 1) + 1)
                + cnc_pkg::FLAG_BITS - 1:0] q_head,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [NORMAL_BITS-1:0] out_axis_x,
  output logic signed [NORMAL_BITS-1:0] out_axis_y,
  output logic signed [NORMAL_BITS-1:0] out_axis_z,
  output logic signed [NORMAL_BITS-1:0] out_cutoff,
  output logic                          out_no_culling,
  output logic                          out_too_many
);

  localparam int EW   = (COORD_BITS > 30) ? 31 : COORD_BITS + 1;
  localparam int CW   = 2 * EW + 1;
  localparam int NB   = NORMAL_BITS;
  localparam int CNTW = $clog2(MAX_TRIANGLES + 1);
  localparam int AW   = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
  localparam int SW   = NB + CNTW + 1;
  localparam int NW   = (CW > SW) ? CW : SW;
  localparam int DTW  = 2 * NB + 2;
  localparam int RTW  = DTW - (NB - 1);
  localparam logic signed [NB-1:0]  UNIT_MAX = {1'b0, {(NB - 1){1'b1}}};
  localparam logic signed [NB-1:0]  UNIT_MIN = {1'b1, {(NB - 1){1'b0}}};
  localparam logic signed [DTW-1:0] HALF     = DTW'(1) << (NB - 2);

  typedef enum logic [3:0] {
    B_IDLE, B_NTRI, B_STORE, B_LAST, B_NAXIS, B_RD, B_MUL, B_ACC, B_EMIT
  } bstate_t;

  bstate_t                state_r;
  cnc_pkg::tri_flags_t    hflags;
  logic signed [CW-1:0]   hc [3];
  logic                   last_r, ovf_r, noc_r;
  logic [CNTW-1:0]        cnt_r, t_r;
  logic signed [SW-1:0]   sum_r [3];
  logic signed [NB-1:0]   axis_r [3];
  logic signed [NB-1:0]   cut_r;
  logic signed [2*NB-1:0] prod_r [3];
  logic                   norm_start, norm_done, sum_zero;
  logic signed [NW-1:0]   nvx, nvy, nvz;
  logic signed [NB-1:0]   nx, ny, nz;
  logic                   ram_we;
  logic [3*NB-1:0]        rdata;
  logic signed [DTW-1:0]  dsum;
  logic signed [RTW-1:0]  dsh;
  logic signed [NB-1:0]   dsat;

  assign {hflags, hc[2], hc[1], hc[0]} = q_head;
  assign sum_zero = (sum_r[0] == '0) && (sum_r[1] == '0) && (sum_r[2] == '0);
  assign q_pop    = (state_r == B_IDLE) && !q_empty;
  assign norm_start = (q_pop && !hflags.drop) || ((state_r == B_LAST) && !sum_zero);
  assign nvx = (state_r == B_IDLE) ? NW'(hc[0]) : NW'(sum_r[0]);
  assign nvy = (state_r == B_IDLE) ? NW'(hc[1]) : NW'(sum_r[1]);
  assign nvz = (state_r == B_IDLE) ? NW'(hc[2]) : NW'(sum_r[2]);
  assign ram_we = (state_r == B_STORE);

  cnc_norm #(
    .NW          (NW),
    .NORMAL_BITS (NB)
  ) u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (norm_start),
    .vx    (nvx),
    .vy    (nvy),
    .vz    (nvz),
    .done  (norm_done),
    .nx    (nx),
    .ny    (ny),
    .nz    (nz)
  );

  cnc_ram #(
    .WIDTH (3 * NB),
    .DEPTH (MAX_TRIANGLES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata ({nz, ny, nx}),
    .raddr (t_r[AW-1:0]),
    .rdata (rdata)
  );

  // Dot product of one stored normal with the axis, rounded and saturated.
  always_comb begin
    dsum = DTW'(prod_r[0]) + DTW'(prod_r[1]) + DTW'(prod_r[2]) + HALF;
    dsh  = RTW'(dsum >>> (NB - 1));
    if (dsh > RTW'(UNIT_MAX)) begin
      dsat = UNIT_MAX;
    end else if (dsh < RTW'(UNIT_MIN)) begin
      dsat = UNIT_MIN;
    end else begin
      dsat = NB'(dsh);
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      out_valid <= 1'b0;
      cnt_r     <= '0;
      ovf_r     <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sum_r[i] <= '0;
      end
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            last_r <= hflags.last;
            if (hflags.drop) begin
              ovf_r   <= 1'b1;
              state_r <= hflags.last ? B_LAST : B_IDLE;
            end else begin
              state_r <= B_NTRI;
            end
          end
        end
        B_NTRI: begin
          if (norm_done) begin
            state_r <= B_STORE;
          end
        end
        B_STORE: begin
          sum_r[0] <= sum_r[0] + SW'(nx);
          sum_r[1] <= sum_r[1] + SW'(ny);
          sum_r[2] <= sum_r[2] + SW'(nz);
          cnt_r    <= CNTW'(cnt_r + 1'b1);
          state_r  <= last_r ? B_LAST : B_IDLE;
        end
        // Cancelled normals give the fallback cone; otherwise the sum is normalised.
        B_LAST: begin
          if (sum_zero) begin
            axis_r[0] <= '0;
            axis_r[1] <= UNIT_MAX;
            axis_r[2] <= '0;
            cut_r     <= UNIT_MIN;
            noc_r     <= 1'b1;
            state_r   <= B_EMIT;
          end else begin
            noc_r   <= 1'b0;
            state_r <= B_NAXIS;
          end
        end
        B_NAXIS: begin
          if (norm_done) begin
            axis_r[0] <= nx;
            axis_r[1] <= ny;
            axis_r[2] <= nz;
            cut_r     <= UNIT_MAX;
            t_r       <= '0;
            state_r   <= (cnt_r == '0) ? B_EMIT : B_RD;
          end
        end
        // Walk the stored normals, each through B_RD, B_MUL and B_ACC.
        B_RD: begin
          state_r <= B_MUL;
        end
        B_MUL: begin
          prod_r[0] <= $signed(rdata[NB-1:0]) * axis_r[0];
          prod_r[1] <= $signed(rdata[2*NB-1:NB]) * axis_r[1];
          prod_r[2] <= $signed(rdata[3*NB-1:2*NB]) * axis_r[2];
          state_r   <= B_ACC;
        end
        B_ACC: begin
          if (dsat < cut_r) begin
            cut_r <= dsat;
          end
          t_r <= CNTW'(t_r + 1'b1);
          state_r <= (CNTW'(t_r + 1'b1) == cnt_r) ? B_EMIT : B_RD;
        end
        B_EMIT: begin
          if (!out_valid) begin
            out_valid      <= 1'b1;
            out_axis_x     <= axis_r[0];
            out_axis_y     <= axis_r[1];
            out_axis_z     <= axis_r[2];
            out_cutoff     <= cut_r;
            out_no_culling <= noc_r;
            out_too_many   <= ovf_r;
            ovf_r          <= 1'b0;
            cnt_r          <= '0;
            for (int i = 0; i < 3; i++) begin
              sum_r[i] <= '0;
            end
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

### sv/cluster_normal_cone_core.sv
// Top level of the cluster normal cone block. Depends on cnc_pkg, cnc_front,
// cnc_fifo and cnc_back.
//
// One triangle is accepted per item as three signed Q16.8 vertices; the item
// marked last closes the cluster and yields one result: the cone axis and the
// cutoff in signed Q1.15, a flag for cancelled normals and a flag for dropped
// triangles. The front end takes a new triangle only once the previous one has
// gone through its edge, product and cross-product steps into a two-entry
// queue. The back end pops one triangle at a time; the shared normaliser
// (scaling, bitwise square root, serial division) takes each one not dropped.
// The last triangle adds one more normalisation and a read, multiply and
// compare per stored normal for the cutoff search through the normal store.
// Triangles beyond MAX_TRIANGLES in a cluster are discarded and reported in too_many.
`timescale 1ns / 1ps

module cluster_normal_cone_core #(
  parameter int MAX_TRIANGLES = 128,
  parameter int COORD_BITS    = 24,
  parameter int NORMAL_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_BITS-1:0]  in_v0_x,
  input  logic signed [COORD_BITS-1:0]  in_v0_y,
  input  logic signed [COORD_BITS-1:0]  in_v0_z,
  input  logic signed [COORD_BITS-1:0]  in_v1_x,
  input  logic signed [COORD_BITS-1:0]  in_v1_y,
  input  logic signed [COORD_BITS-1:0]  in_v1_z,
  input  logic signed [COORD_BITS-1:0]  in_v2_x,
  input  logic signed [COORD_BITS-1:0]  in_v2_y,
  input  logic signed [COORD_BITS-1:0]  in_v2_z,
  input  logic                          in_last_triangle,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [NORMAL_BITS-1:0] out_axis_x,
  output logic signed [NORMAL_BITS-1:0] out_axis_y,
  output logic signed [NORMAL_BITS-1:0] out_axis_z,
  output logic signed [NORMAL_BITS-1:0] out_cutoff,
  output logic                          out_no_culling,
  output logic                          out_too_many
);

  localparam int EW = (COORD_BITS > 30) ? 31 : COORD_BITS + 1;
  localparam int QW = 3 * (2 * EW + 1) + cnc_pkg::FLAG_BITS;

  logic          push, q_full, q_pop, q_empty;
  logic [QW-1:0] push_data, q_head;

  cnc_front #(
    .MAX_TRIANGLES (MAX_TRIANGLES),
    .COORD_BITS    (COORD_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .v0_x          (in_v0_x),
    .v0_y          (in_v0_y),
    .v0_z          (in_v0_z),
    .v1_x          (in_v1_x),
    .v1_y          (in_v1_y),
    .v1_z          (in_v1_z),
    .v2_x          (in_v2_x),
    .v2_y          (in_v2_y),
    .v2_z          (in_v2_z),
    .last_triangle (in_last_triangle),
    .push          (push),
    .push_data     (push_data),
    .q_full        (q_full)
  );

  cnc_fifo #(
    .WIDTH (QW),
    .DEPTH (2)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  cnc_back #(
    .MAX_TRIANGLES (MAX_TRIANGLES),
    .COORD_BITS    (COORD_BITS),
    .NORMAL_BITS   (NORMAL_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_axis_x     (out_axis_x),
    .out_axis_y     (out_axis_y),
    .out_axis_z     (out_axis_z),
    .out_cutoff     (out_cutoff),
    .out_no_culling (out_no_culling),
    .out_too_many   (out_too_many)
  );

endmodule

### sv/cnc_checker.sv
// Port-level checks of the cluster normal cone block, bound to its top level.
// Depends on cluster_normal_cone_core.
`timescale 1ns / 1ps

module cnc_checker #(
  parameter int NORMAL_BITS = 16
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [NORMAL_BITS-1:0] out_axis_x,
  input logic signed [NORMAL_BITS-1:0] out_axis_y,
  input logic signed [NORMAL_BITS-1:0] out_axis_z,
  input logic signed [NORMAL_BITS-1:0] out_cutoff,
  input logic                          out_no_culling
);

  localparam logic signed [NORMAL_BITS-1:0] UMAX = {1'b0, {(NORMAL_BITS - 1){1'b1}}};
  localparam logic signed [NORMAL_BITS-1:0] UMIN = {1'b1, {(NORMAL_BITS - 1){1'b0}}};

  // A stalled result stays offered.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  // A taken result is never offered again in the next cycle.
  a_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid)
    else $error("result repeated");

  // The fallback cone has its fixed shape.
  a_fallback: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_culling |->
      out_axis_x == '0 && out_axis_z == '0 && out_axis_y == UMAX && out_cutoff == UMIN)
    else $error("fallback cone malformed");

  // A normalised axis is never the zero vector.
  a_axis: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_no_culling |->
      (out_axis_x != '0 || out_axis_y != '0 || out_axis_z != '0))
    else $error("zero cone axis");

endmodule

bind cluster_normal_cone_core cnc_checker #(
  .NORMAL_BITS (NORMAL_BITS)
) u_cnc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_axis_x     (out_axis_x),
  .out_axis_y     (out_axis_y),
  .out_axis_z     (out_axis_z),
  .out_cutoff     (out_cutoff),
  .out_no_culling (out_no_culling)
);

### test/cluster_normal_cone_core_tb.sv
// Self-checking testbench for cluster_normal_cone_core: a directed table and
// random clusters of triangles, each result checked against a local predictor
// or a row's own expected cone. Depends on the block's RTL only.
`timescale 1ns / 1ps

module cluster_normal_cone_core_tb;

  localparam int  CAP        = 128;
  localparam int  NUM_ITEMS  = 550;
  localparam int  QUIET_FROM = 470;
  localparam int  HOLD_OFF   = 1500;
  localparam int  WATCH_MAX  = 20000;
  localparam int  TAIL       = 300;
  localparam int  UNIT_HI    = 32767;
  localparam int  UNIT_LO    = -32768;

  typedef struct packed {
    logic signed [15:0] ax, ay, az, cut;
    logic               noc, many;
  } cone_t;

  typedef struct {
    logic signed [23:0] c[9];
    logic               last;
    bit                 typed;
    cone_t              want;
  } tri_row_t;

  typedef longint wide3_t[3];
  typedef int     unit3_t[3];

  logic clk, rst_n;
  logic in_valid, in_stall, in_last_triangle;
  logic signed [23:0] in_v0_x, in_v0_y, in_v0_z, in_v1_x, in_v1_y, in_v1_z;
  logic signed [23:0] in_v2_x, in_v2_y, in_v2_z;
  logic out_valid, out_stall, out_no_culling, out_too_many;
  logic signed [15:0] out_axis_x, out_axis_y, out_axis_z, out_cutoff;

  cluster_normal_cone_core DUT (.*);

  // Predictor state: stored normals, running sum, count and overflow flag.
  int     cone_normals[CAP][3];
  longint cone_sum[3];
  int     cone_count;
  bit     cone_overflow;

  cone_t    cone_expected[$];
  tri_row_t plan[$];
  int       errors, items_sent, clusters_done, fallbacks_seen, overflows_seen;
  bit       quiet, hold_req;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Appends one row to the stimulus table.
  function automatic void add_row(input tri_row_t r);
    plan = {plan, r};
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Scale to unit length in Q1.15; a zero vector stays zero.
  function automatic unit3_t unit_of(input wide3_t v);
    longint unsigned mg[3], m, len, q;
    unit3_t o;
    for (int i = 0; i < 3; i++) mg[i] = v[i] < 0 ? -v[i] : v[i];
    m = mg[0];
    if (mg[1] > m) m = mg[1];
    if (mg[2] > m) m = mg[2];
    o = '{0, 0, 0};
    if (m == 0) return o;
    while (m >= (64'h1 << 30)) begin
      m >>= 1;
      for (int i = 0; i < 3; i++) mg[i] >>= 1;
    end
    while (m < (64'h1 << 29)) begin
      m <<= 1;
      for (int i = 0; i < 3; i++) mg[i] <<= 1;
    end
    len = int_sqrt(mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2]);
    for (int i = 0; i < 3; i++) begin
      q = ((mg[i] << 15) + (len >> 1)) / len;
      if (q > UNIT_HI) q = UNIT_HI;
      o[i] = v[i] < 0 ? -int'(q) : int'(q);
    end
    return o;
  endfunction

  // Takes one accepted triangle; returns 1 with the cone when it closes a cluster.
  function automatic bit cone_update(input tri_row_t t, output cone_t r);
    longint e1[3], e2[3], d, cut;
    wide3_t cr;
    unit3_t n, ax;
    r = '0;
    if (cone_count >= CAP) begin
      cone_overflow = 1'b1;
    end else begin
      for (int i = 0; i < 3; i++) begin
        e1[i] = longint'(t.c[3 + i]) - longint'(t.c[i]);
        e2[i] = longint'(t.c[6 + i]) - longint'(t.c[i]);
      end
      cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
      cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
      cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
      n = unit_of(cr);
      for (int i = 0; i < 3; i++) begin
        cone_normals[cone_count][i] = n[i];
        cone_sum[i] += n[i];
      end
      cone_count++;
    end
    if (!t.last) return 0;
    if (cone_sum[0] == 0 && cone_sum[1] == 0 && cone_sum[2] == 0) begin
      ax = '{0, UNIT_HI, 0};
      cut = UNIT_LO;
      r.noc = 1'b1;
    end else begin
      ax = unit_of(cone_sum);
      cut = UNIT_HI;
      for (int k = 0; k < cone_count; k++) begin
        d = 0;
        for (int i = 0; i < 3; i++) d += longint'(cone_normals[k][i]) * ax[i];
        d = (d + 16384) >>> 15;
        if (d > UNIT_HI) d = UNIT_HI;
        if (d < UNIT_LO) d = UNIT_LO;
        if (d < cut) cut = d;
      end
    end
    r.ax = 16'(ax[0]);
    r.ay = 16'(ax[1]);
    r.az = 16'(ax[2]);
    r.cut = 16'(cut);
    r.many = cone_overflow;
    cone_sum = '{0, 0, 0};
    cone_count = 0;
    cone_overflow = 1'b0;
    return 1;
  endfunction

  // Random triangle: mostly full range, some small, some degenerate.
  function automatic tri_row_t random_tri(input bit last);
    tri_row_t t;
    int kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++)
      t.c[i] = (kind == 1) ? 24'($signed($urandom_range(0, 2047)) - 1024) : 24'($urandom);
    if (kind == 0) begin
      for (int i = 0; i < 3; i++) t.c[6 + i] = t.c[3 + i];
    end
    t.last = last;
    t.typed = 1'b0;
    t.want = '0;
    return t;
  endfunction

  task automatic send_tri(input tri_row_t t, input bit gappy);
    cone_t r;
    if (gappy && !quiet && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_v0_x, in_v0_y, in_v0_z} <= {t.c[0], t.c[1], t.c[2]};
    {in_v1_x, in_v1_y, in_v1_z} <= {t.c[3], t.c[4], t.c[5]};
    {in_v2_x, in_v2_y, in_v2_z} <= {t.c[6], t.c[7], t.c[8]};
    in_last_triangle <= t.last;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (items_sent >= QUIET_FROM) quiet = 1'b1;
    if (cone_update(t, r)) begin
      clusters_done++;
      fallbacks_seen += r.noc;
      overflows_seen += r.many;
      cone_expected = {cone_expected, (t.typed ? t.want : r)};
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Result checking and the stall watchdog.
  int idle_cycles;
  always @(posedge clk) begin
    cone_t want;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCH_MAX) begin
        $display("cluster_normal_cone_core_tb NOT OK");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (cone_expected.size() == 0) begin
          $error("result with no cluster closed");
          errors++;
        end else begin
          want = cone_expected.pop_front();
          check_field("axis_x", want.ax, out_axis_x);
          check_field("axis_y", want.ay, out_axis_y);
          check_field("axis_z", want.az, out_axis_z);
          check_field("cutoff", want.cut, out_cutoff);
          check_field("no_culling", want.noc, out_no_culling);
          check_field("too_many", want.many, out_too_many);
        end
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off on request, none at the end.
  initial begin
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF) @(posedge clk);
      end else if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Stimulus.
  initial begin
    int len;
    bit gappy;
    errors = 0;
    items_sent = 0;
    clusters_done = 0;
    fallbacks_seen = 0;
    overflows_seen = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    cone_sum = '{0, 0, 0};
    cone_count = 0;
    cone_overflow = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_last_triangle <= 1'b0;
    {in_v0_x, in_v0_y, in_v0_z, in_v1_x, in_v1_y, in_v1_z} <= '0;
    {in_v2_x, in_v2_y, in_v2_z} <= '0;

    // Directed table: degenerate, axis-aligned, cancelling pair, extremes.
    add_row('{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, 1'b1,
              '{16'sd0, 16'sd32767, 16'sd0, 16'sh8000, 1'b1, 1'b0}});
    add_row('{'{0, 0, 0, 256, 0, 0, 0, 256, 0}, 1'b1, 1'b1,
              '{16'sd0, 16'sd0, 16'sd32767, 16'sd32766, 1'b0, 1'b0}});
    add_row('{'{0, 0, 0, 0, 256, 0, 256, 0, 0}, 1'b1, 1'b1,
              '{16'sd0, 16'sd0, -16'sd32767, 16'sd32766, 1'b0, 1'b0}});
    add_row('{'{0, 0, 0, 256, 0, 0, 0, 256, 0}, 1'b0, 1'b0, '0});
    add_row('{'{0, 0, 0, 0, 256, 0, 256, 0, 0}, 1'b1, 1'b1,
              '{16'sd0, 16'sd32767, 16'sd0, 16'sh8000, 1'b1, 1'b0}});
    add_row('{'{-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
                8388607, -8388608, 0}, 1'b0, 1'b0, '0});
    add_row('{'{8388607, 8388607, 8388607, -8388608, 8388607, -8388608,
                0, -8388608, 8388607}, 1'b0, 1'b0, '0});
    add_row('{'{0, 0, 0, 100, 200, 300, 200, 400, 600}, 1'b0, 1'b0, '0});
    add_row('{'{5, -7, 9, 1000, 2000, -3000, 1000, 2000, -3000}, 1'b1, 1'b0, '0});
    add_row('{'{0, 0, 0, 1, 0, 0, 0, 0, 1}, 1'b0, 1'b0, '0});
    add_row('{'{-1, -1, -1, 0, -1, -1, -1, 0, -1}, 1'b1, 1'b0, '0});
    add_row('{'{-8388608, -8388608, -8388608, 8388607, -8388608, -8388608,
                -8388608, 8388607, -8388608}, 1'b1, 1'b0, '0});
    add_row('{'{8388607, 0, -8388608, -8388608, 8388607, 0,
                0, -8388608, 8388607}, 1'b1, 1'b0, '0});

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) send_tri(plan[i], 1'b0);

    // Long receiver hold-off while single-triangle clusters keep coming.
    hold_req = 1'b1;
    for (int i = 0; i < 20; i++) send_tri(random_tri(1'b1), 1'b0);

    // One cluster exactly at capacity, one beyond it.
    for (int i = 0; i < CAP; i++) send_tri(random_tri(i == CAP - 1), 1'b1);
    for (int i = 0; i < CAP + 5; i++) send_tri(random_tri(i == CAP + 4), 1'b1);

    // Random clusters of a few triangles; idling switched on and off in stretches.
    gappy = 1'b1;
    while (items_sent < NUM_ITEMS) begin
      len = $urandom_range(1, 8);
      if ($urandom_range(0, 5) == 0) gappy = !gappy;
      for (int i = 0; i < len; i++) send_tri(random_tri(i == len - 1), gappy);
    end
    in_valid <= 1'b0;

    while (cone_expected.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);

    $display("Sent %0d triangles in %0d clusters: %0d fallback cones, %0d over capacity.",
             items_sent, clusters_done, fallbacks_seen, overflows_seen);
    if (errors == 0 && cone_expected.size() == 0) begin
      $display("cluster_normal_cone_core_tb OK");
    end else begin
      $display("cluster_normal_cone_core_tb NOT OK");
    end
    $finish;
  end

endmodule

### cluster_normal_cone_core.f
sv/cnc_pkg.sv
sv/cnc_ram.sv
sv/cnc_fifo.sv
sv/cnc_front.sv
sv/cnc_norm.sv
sv/cnc_back.sv
sv/cluster_normal_cone_core.sv
sv/cnc_checker.sv
test/cluster_normal_cone_core_tb.sv
